[sv/arp_cache_with_request_retry_top_assert.svh]
// Assertion macros for the ARP cache block checker.
// Used by the checker module; no other dependencies.
`ifndef ARP_CACHE_WITH_REQUEST_RETRY_TOP_ASSERT_SVH
`define ARP_CACHE_WITH_REQUEST_RETRY_TOP_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define ARPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// next-cycle implication, checked while out of reset
`define ARPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`endif

[sv/arpc_pkg.sv]
// Shared codes and controller/datapath interface types for the ARP cache.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package arpc_pkg;

  localparam logic [2:0] FUNC_LOOKUP = 3'd0;
  localparam logic [2:0] FUNC_QUEUE  = 3'd1;
  localparam logic [2:0] FUNC_INSERT = 3'd2;
  localparam logic [2:0] FUNC_TICK   = 3'd3;
  localparam logic [2:0] FUNC_REMOVE = 3'd4;
  localparam logic [2:0] FUNC_CLEAR  = 3'd5;

  localparam logic [2:0] KIND_LOOKUP = 3'd0;
  localparam logic [2:0] KIND_QUEUED = 3'd1;
  localparam logic [2:0] KIND_INSERT = 3'd2;
  localparam logic [2:0] KIND_SEND   = 3'd3;
  localparam logic [2:0] KIND_GIVEUP = 3'd4;
  localparam logic [2:0] KIND_DONE   = 3'd5;

  localparam logic [7:0] CFG_TIMEOUT   = 8'd0;
  localparam logic [7:0] CFG_MAX_SENDS = 8'd1;

  typedef struct packed {
    logic capture;
    logic exec;
    logic emit_res;
    logic idx_clr;
    logic idx_inc;
    logic age_step;
    logic req_emit;
    logic set_done;
  } arpc_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       idx_last_entry;
    logic       idx_last_req;
    logic       req_live;
    logic       out_free;
  } arpc_status_t;

endpackage
`default_nettype wire

[sv/arpc_ctrl.sv]
// Controller state machine for the ARP cache.
// Depends on arpc_pkg; drives the datapath through arpc_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module arpc_ctrl
  import arpc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire arpc_status_t status,
  output arpc_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_AGE  = 3'd3;
  localparam logic [2:0] S_REQ  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.func == FUNC_TICK) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_AGE;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_res = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_AGE: begin
        cmd.age_step = 1'b1;
        if (status.idx_last_entry) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_REQ;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_REQ: begin
        if (!status.req_live || status.out_free) begin
          cmd.req_emit = status.req_live;
          if (status.idx_last_req) begin
            cmd.set_done = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/arpc_datapath.sv]
// Datapath of the ARP cache: tables, config registers, output register.
// Depends on arpc_pkg; commanded by arpc_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module arpc_datapath
  import arpc_pkg::*;
#(
  parameter int CACHE_DEPTH   = 32,
  parameter int REQUEST_DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire arpc_cmd_t    cmd,
  output arpc_status_t      status,
  input  wire logic [2:0]   in_func,
  input  wire logic [31:0]  in_ip,
  input  wire logic [47:0]  in_mac,
  input  wire logic         cfg_valid,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [2:0]        out_kind,
  output logic              out_hit,
  output logic [4:0]        out_slot,
  output logic [31:0]       out_ip,
  output logic [47:0]       out_mac,
  output logic              out_full,
  output logic              out_last
);

  localparam int EW    = $clog2(CACHE_DEPTH);
  localparam int RW    = (REQUEST_DEPTH > 1) ? $clog2(REQUEST_DEPTH) : 1;
  localparam int MAXD  = (CACHE_DEPTH > REQUEST_DEPTH) ? CACHE_DEPTH : REQUEST_DEPTH;
  localparam int IW    = $clog2(MAXD);

  logic [15:0] timeout_r;
  logic [7:0]  max_sends_r;

  logic [2:0]  func_r;
  logic [31:0] ip_r;
  logic [47:0] mac_r;

  logic [CACHE_DEPTH-1:0]   entry_valid_r;
  logic [31:0]              entry_ip_r   [CACHE_DEPTH];
  logic [15:0]              entry_age_r  [CACHE_DEPTH];
  logic [47:0]              entry_mac_mem[CACHE_DEPTH];
  logic [47:0]              mac_rd_r;
  logic [REQUEST_DEPTH-1:0] req_valid_r;
  logic [31:0]              req_ip_r     [REQUEST_DEPTH];
  logic [7:0]               req_sends_r  [REQUEST_DEPTH];

  logic [IW-1:0] idx_r;

  logic [2:0] res_kind_r;
  logic       res_hit_r;
  logic [4:0] res_slot_r;
  logic       res_full_r;

  logic [CACHE_DEPTH-1:0]   e_match, e_free;
  logic [REQUEST_DEPTH-1:0] r_match, r_free;
  logic [IW-1:0] e_idx, f_idx, r_idx, q_idx;
  logic          e_hit, f_hit, r_hit, q_hit;

  logic [EW-1:0] e_at;
  logic [RW-1:0] r_at;

  function automatic logic [4:0] to_slot(input logic [IW-1:0] v);
    logic [IW+4:0] t;
    t = {5'd0, v};
    return t[4:0];
  endfunction

  always_comb begin
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      e_match[i] = entry_valid_r[i] && (entry_ip_r[i] == ip_r);
      e_free[i]  = !entry_valid_r[i];
    end
    for (int i = 0; i < REQUEST_DEPTH; i++) begin
      r_match[i] = req_valid_r[i] && (req_ip_r[i] == ip_r);
      r_free[i]  = !req_valid_r[i];
    end
  end

  always_comb begin
    e_idx = '0;
    f_idx = '0;
    for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
      if (e_match[i]) e_idx = IW'(i);
      if (e_free[i])  f_idx = IW'(i);
    end
    r_idx = '0;
    q_idx = '0;
    for (int i = REQUEST_DEPTH - 1; i >= 0; i--) begin
      if (r_match[i]) r_idx = IW'(i);
      if (r_free[i])  q_idx = IW'(i);
    end
  end

  assign e_hit = |e_match;
  assign f_hit = |e_free;
  assign r_hit = |r_match;
  assign q_hit = |r_free;
  assign e_at  = idx_r[EW-1:0];
  assign r_at  = idx_r[RW-1:0];

  assign status.func           = func_r;
  assign status.idx_last_entry = (idx_r == IW'(CACHE_DEPTH - 1));
  assign status.idx_last_req   = (idx_r == IW'(REQUEST_DEPTH - 1));
  assign status.req_live       = req_valid_r[r_at];
  assign status.out_free       = !out_valid || out_ready;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= 16'd30;
      max_sends_r <= 8'd5;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TIMEOUT)   timeout_r   <= cfg_data;
      if (cfg_index == CFG_MAX_SENDS) max_sends_r <= cfg_data[7:0];
    end
  end

  // item capture and index counter
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      ip_r   <= in_ip;
      mac_r  <= in_mac;
    end
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // MAC store, registered read at the lowest match
  always_ff @(posedge clk) begin
    mac_rd_r <= entry_mac_mem[e_idx[EW-1:0]];
    if (cmd.exec && func_r == FUNC_INSERT && f_hit) begin
      entry_mac_mem[f_idx[EW-1:0]] <= mac_r;
    end
  end

  // cache entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
    end else if (cmd.exec && func_r == FUNC_CLEAR) begin
      entry_valid_r <= '0;
    end else if (cmd.exec && func_r == FUNC_INSERT && f_hit) begin
      entry_valid_r[f_idx[EW-1:0]] <= 1'b1;
    end else if (cmd.age_step && entry_valid_r[e_at]) begin
      if (entry_age_r[e_at] >= timeout_r) entry_valid_r[e_at] <= 1'b0;
    end
    if (cmd.exec && func_r == FUNC_INSERT && f_hit) begin
      entry_ip_r[f_idx[EW-1:0]]  <= ip_r;
      entry_age_r[f_idx[EW-1:0]] <= 16'd0;
    end else if (cmd.age_step && entry_valid_r[e_at]
                 && entry_age_r[e_at] < timeout_r) begin
      entry_age_r[e_at] <= entry_age_r[e_at] + 16'd1;
    end
  end

  // pending requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= '0;
    end else if (cmd.exec && func_r == FUNC_CLEAR) begin
      req_valid_r <= '0;
    end else if (cmd.exec && func_r == FUNC_QUEUE && !r_hit && q_hit) begin
      req_valid_r[q_idx[RW-1:0]] <= 1'b1;
    end else if (cmd.exec && func_r == FUNC_REMOVE && r_hit) begin
      req_valid_r[r_idx[RW-1:0]] <= 1'b0;
    end else if (cmd.req_emit && req_sends_r[r_at] >= max_sends_r) begin
      req_valid_r[r_at] <= 1'b0;
    end
    if (cmd.exec && func_r == FUNC_QUEUE && !r_hit && q_hit) begin
      req_ip_r[q_idx[RW-1:0]]    <= ip_r;
      req_sends_r[q_idx[RW-1:0]] <= 8'd0;
    end else if (cmd.req_emit && req_sends_r[r_at] < max_sends_r
                 && req_sends_r[r_at] != 8'hFF) begin
      req_sends_r[r_at] <= req_sends_r[r_at] + 8'd1;
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.set_done) begin
      res_kind_r <= KIND_DONE;
      res_hit_r  <= 1'b0;
      res_slot_r <= 5'd0;
      res_full_r <= 1'b0;
    end else if (cmd.exec) begin
      res_hit_r  <= 1'b0;
      res_slot_r <= 5'd0;
      res_full_r <= 1'b0;
      unique case (func_r)
        FUNC_LOOKUP: begin
          res_kind_r <= KIND_LOOKUP;
          res_hit_r  <= e_hit;
          res_slot_r <= e_hit ? to_slot(e_idx) : 5'd0;
        end
        FUNC_QUEUE: begin
          res_kind_r <= KIND_QUEUED;
          if (r_hit)      res_slot_r <= to_slot(r_idx);
          else if (q_hit) res_slot_r <= to_slot(q_idx);
          else            res_full_r <= 1'b1;
        end
        FUNC_INSERT: begin
          res_kind_r <= KIND_INSERT;
          res_hit_r  <= r_hit;
          res_slot_r <= f_hit ? to_slot(f_idx) : 5'd0;
          res_full_r <= !f_hit;
        end
        FUNC_REMOVE: begin
          res_kind_r <= KIND_DONE;
          res_hit_r  <= r_hit;
          res_slot_r <= r_hit ? to_slot(r_idx) : 5'd0;
        end
        default: res_kind_r <= KIND_DONE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_res || cmd.req_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit_res) begin
      out_kind <= res_kind_r;
      out_hit  <= res_hit_r;
      out_slot <= res_slot_r;
      out_ip   <= 32'd0;
      out_mac  <= (res_kind_r == KIND_LOOKUP && res_hit_r) ? mac_rd_r : 48'd0;
      out_full <= res_full_r;
      out_last <= 1'b1;
    end else if (cmd.req_emit) begin
      out_kind <= (req_sends_r[r_at] >= max_sends_r) ? KIND_GIVEUP : KIND_SEND;
      out_hit  <= 1'b0;
      out_slot <= to_slot(idx_r);
      out_ip   <= req_ip_r[r_at];
      out_mac  <= 48'd0;
      out_full <= 1'b0;
      out_last <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[sv/arp_cache_with_request_retry_top.sv]
// ARP cache with aging and pending-request retry.
// Channels: in_* carries one operation per item (in_tuser = func,
// in_tdata = ip_addr, mac_addr); out_* carries result items
// (out_tuser = kind, out_tlast = final result of the operation);
// cfg_* writes entry_timeout_ticks (index 0) and max_sends (index 1).
// Lookup, queue, insert, remove, clear and unused codes each give one
// result; an item passes through the execute and emit states after accept,
// and the next item is taken after the result is loaded into the output register.
// A tick walks the cache one entry per cycle, then the request table one
// slot per cycle while the receiver does not stall, ending with a done result.
// Reset (rst_n low, synchronous) invalidates all entries and requests and
// loads timeout 30, max_sends 5. If the receiver stalls, the output
// register holds its item and the walk waits.
// Depends on arpc_pkg, arpc_ctrl, arpc_datapath.
`timescale 1ns / 1ps
`default_nettype none
module arp_cache_with_request_retry_top
  import arpc_pkg::*;
#(
  parameter int CACHE_DEPTH   = 32,
  parameter int REQUEST_DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [79:0]  in_tdata,   // ip_addr[31:0], mac_addr[79:32]
  input  wire logic [2:0]   in_tuser,   // func
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [87:0]       out_tdata,  // hit, slot, result_ip, result_mac, table_full, pad
  output logic [2:0]        out_tuser,  // kind
  output logic              out_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  arpc_cmd_t    cmd;
  arpc_status_t status;
  logic         o_hit, o_full;
  logic [4:0]   o_slot;
  logic [31:0]  o_ip;
  logic [47:0]  o_mac;

  assign cfg_ready = 1'b1;
  assign out_tdata = {1'b0, o_full, o_mac, o_ip, o_slot, o_hit};

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  arpc_datapath #(
    .CACHE_DEPTH   (CACHE_DEPTH),
    .REQUEST_DEPTH (REQUEST_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_func   (in_tuser),
    .in_ip     (in_tdata[31:0]),
    .in_mac    (in_tdata[79:32]),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_hit   (o_hit),
    .out_slot  (o_slot),
    .out_ip    (o_ip),
    .out_mac   (o_mac),
    .out_full  (o_full),
    .out_last  (out_tlast)
  );

endmodule
`default_nettype wire

[sv/arpc_checker.sv]
// Port-level checks for the ARP cache top level, bound to it below.
// Depends on arpc_pkg and arp_cache_with_request_retry_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
module arpc_checker
  import arpc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [2:0] out_tuser,
  input wire logic       out_tlast
);

`include "arp_cache_with_request_retry_top_assert.svh"

  `ARPC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `ARPC_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `ARPC_ASSERT_NOW(a_retry_not_last,
    out_tvalid && (out_tuser == KIND_SEND || out_tuser == KIND_GIVEUP), !out_tlast)
  `ARPC_ASSERT_NOW(a_lookup_last, out_tvalid && out_tuser == KIND_LOOKUP, out_tlast)

endmodule

bind arp_cache_with_request_retry_top arpc_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

[sim/arp_cache_with_request_retry_top_tb.sv]
// Self-checking bench for the ARP cache with aging and request retry.
// Drives operations on in_*, writes cfg_*, checks out_* against a predictor.
// Depends on arpc_pkg and arp_cache_with_request_retry_top.
`timescale 1ns / 1ps
`default_nettype none
module arp_cache_with_request_retry_top_tb;
  import arpc_pkg::*;

  localparam int NCACHE = 32;
  localparam int NREQ = 16;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [2:0]  kind;
    logic        hit;
    logic [4:0]  slot;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        full;
    logic        last;
  } arp_res_t;

  typedef struct {
    logic [2:0]  func;
    logic [31:0] ip;
    logic [47:0] mac;
    bit          known;
    arp_res_t    res;
  } arp_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  arp_cache_with_request_retry_top dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic [15:0] m_timeout;
  logic [7:0]  m_max_sends;
  bit          m_evalid[NCACHE];
  logic [31:0] m_eip[NCACHE];
  logic [47:0] m_emac[NCACHE];
  logic [15:0] m_eage[NCACHE];
  bit          m_rvalid[NREQ];
  logic [31:0] m_rip[NREQ];
  logic [7:0]  m_rsends[NREQ];

  arp_res_t pending_results[$];
  arp_op_t  ops[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic arp_res_t mk(logic [2:0] k, logic h, int s, logic [31:0] ip,
                                  logic [47:0] mac, logic f, logic l);
    arp_res_t r;
    r.kind = k; r.hit = h; r.slot = s[4:0]; r.ip = ip; r.mac = mac;
    r.full = f; r.last = l;
    return r;
  endfunction

  function automatic void queue_result(arp_res_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic int find_request(logic [31:0] ip);
    for (int i = 0; i < NREQ; i++)
      if (m_rvalid[i] && m_rip[i] == ip) return i;
    return -1;
  endfunction

  task automatic predict_operation(arp_op_t op);
    int r;
    int e;
    r = -1;
    e = -1;
    case (op.func)
      FUNC_LOOKUP: begin
        for (int i = 0; i < NCACHE; i++)
          if (r < 0 && m_evalid[i] && m_eip[i] == op.ip) r = i;
        if (r >= 0) queue_result(mk(KIND_LOOKUP, 1, r, 0, m_emac[r], 0, 1));
        else queue_result(mk(KIND_LOOKUP, 0, 0, 0, 0, 0, 1));
      end
      FUNC_QUEUE: begin
        r = find_request(op.ip);
        if (r < 0)
          for (int i = 0; i < NREQ; i++)
            if (r < 0 && !m_rvalid[i]) begin
              r = i; m_rvalid[i] = 1; m_rip[i] = op.ip; m_rsends[i] = 0;
            end
        if (r < 0) queue_result(mk(KIND_QUEUED, 0, 0, 0, 0, 1, 1));
        else queue_result(mk(KIND_QUEUED, 0, r, 0, 0, 0, 1));
      end
      FUNC_INSERT: begin
        for (int i = 0; i < NCACHE; i++)
          if (e < 0 && !m_evalid[i]) begin
            e = i; m_evalid[i] = 1; m_eip[i] = op.ip; m_emac[i] = op.mac; m_eage[i] = 0;
          end
        r = find_request(op.ip);
        queue_result(mk(KIND_INSERT, r >= 0, e < 0 ? 0 : e, 0, 0, e < 0, 1));
      end
      FUNC_TICK: begin
        for (int i = 0; i < NCACHE; i++)
          if (m_evalid[i]) begin
            if (m_eage[i] >= m_timeout) m_evalid[i] = 0;
            else m_eage[i]++;
          end
        for (int i = 0; i < NREQ; i++)
          if (m_rvalid[i]) begin
            if (m_rsends[i] >= m_max_sends) begin
              queue_result(mk(KIND_GIVEUP, 0, i, m_rip[i], 0, 0, 0));
              m_rvalid[i] = 0;
            end else begin
              queue_result(mk(KIND_SEND, 0, i, m_rip[i], 0, 0, 0));
              if (m_rsends[i] != 8'hff) m_rsends[i]++;
            end
          end
        queue_result(mk(KIND_DONE, 0, 0, 0, 0, 0, 1));
      end
      FUNC_REMOVE: begin
        r = find_request(op.ip);
        if (r >= 0) begin
          m_rvalid[r] = 0;
          queue_result(mk(KIND_DONE, 1, r, 0, 0, 0, 1));
        end else queue_result(mk(KIND_DONE, 0, 0, 0, 0, 0, 1));
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < NCACHE; i++) m_evalid[i] = 0;
        for (int i = 0; i < NREQ; i++) m_rvalid[i] = 0;
        queue_result(mk(KIND_DONE, 0, 0, 0, 0, 0, 1));
      end
      default: queue_result(mk(KIND_DONE, 0, 0, 0, 0, 0, 1));
    endcase
  endtask

  // receiver: own stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else if ($urandom_range(0, 15) < 2) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // check results and watchdog
  always @(posedge clk) begin
    arp_res_t got;
    arp_res_t want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
          || hold_off)
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("simulation failed");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got = mk(out_tuser, out_tdata[0], out_tdata[5:1], out_tdata[37:6],
                 out_tdata[85:38], out_tdata[86], out_tlast);
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_register(logic [7:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TIMEOUT) m_timeout = val;
    else if (idx == CFG_MAX_SENDS) m_max_sends = val[7:0];
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NCACHE + NREQ + 10) @(posedge clk);
  endtask

  task automatic send_items();
    arp_op_t op;
    int burst;
    while (ops.size() != 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && ops.size() != 0) begin
        op = ops.pop_front();
        in_tuser <= op.func;
        in_tdata <= {op.mac, op.ip};
        in_tvalid <= 1'b1;
        do @(posedge clk); while (!in_tready);
        if (op.known) queue_result(op.res);
        predict_operation(op);
        if (op.known) void'(pending_results.pop_back());
        burst--;
      end
      if (ops.size() != 0 && $urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  function automatic void add(logic [2:0] f, logic [31:0] ip, logic [47:0] mac,
                              bit known = 0, arp_res_t res = '0);
    arp_op_t op;
    op.func = f; op.ip = ip; op.mac = mac; op.known = known; op.res = res;
    ops = {ops, op};
  endfunction

  function automatic logic [31:0] pick_ip();
    return ($urandom_range(0, 9) == 0) ? $urandom : 32'h0a00_0000 | $urandom_range(0, 23);
  endfunction

  task automatic add_random(int n);
    int u;
    for (int k = 0; k < n; k++) begin
      u = $urandom_range(0, 99);
      if (u < 25) add(FUNC_LOOKUP, pick_ip(), {$urandom, $urandom});
      else if (u < 45) add(FUNC_QUEUE, pick_ip(), {$urandom, $urandom});
      else if (u < 70) add(FUNC_INSERT, pick_ip(), {$urandom, $urandom});
      else if (u < 84) add(FUNC_TICK, pick_ip(), {$urandom, $urandom});
      else if (u < 94) add(FUNC_REMOVE, pick_ip(), {$urandom, $urandom});
      else if (u < 96) add(FUNC_CLEAR, $urandom, {$urandom, $urandom});
      else add(3'($urandom_range(6, 7)), $urandom, {$urandom, $urandom});
    end
  endtask

  initial begin
    m_timeout = 16'd30;
    m_max_sends = 8'd5;
    for (int i = 0; i < NCACHE; i++) m_evalid[i] = 0;
    for (int i = 0; i < NREQ; i++) m_rvalid[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    add(FUNC_LOOKUP, 32'h0, 48'h0, 1, mk(KIND_LOOKUP, 0, 0, 0, 0, 0, 1));
    add(FUNC_TICK, 32'h0, 48'h0, 1, mk(KIND_DONE, 0, 0, 0, 0, 0, 1));
    add(FUNC_REMOVE, 32'hffff_ffff, 48'h0, 1, mk(KIND_DONE, 0, 0, 0, 0, 0, 1));
    add(FUNC_INSERT, 32'hffff_ffff, 48'hffff_ffff_ffff, 1, mk(KIND_INSERT, 0, 0, 0, 0, 0, 1));
    add(FUNC_LOOKUP, 32'hffff_ffff, 48'h0, 1,
        mk(KIND_LOOKUP, 1, 0, 0, 48'hffff_ffff_ffff, 0, 1));
    add(FUNC_INSERT, 32'hffff_ffff, 48'h1234_5678_9abc);
    add(FUNC_LOOKUP, 32'hffff_ffff, 48'h0);
    add(FUNC_QUEUE, 32'h0, 48'h0, 1, mk(KIND_QUEUED, 0, 0, 0, 0, 0, 1));
    add(FUNC_QUEUE, 32'h0, 48'h0, 1, mk(KIND_QUEUED, 0, 0, 0, 0, 0, 1));
    add(FUNC_QUEUE, 32'h5555_aaaa, 48'h0);
    add(FUNC_INSERT, 32'h0, 48'h0, 1, mk(KIND_INSERT, 1, 2, 0, 0, 0, 1));
    add(FUNC_TICK, 32'h0, 48'h0);
    add(FUNC_REMOVE, 32'h5555_aaaa, 48'h0);
    add(3'd6, 32'h0, 48'h0, 1, mk(KIND_DONE, 0, 0, 0, 0, 0, 1));
    add(3'd7, 32'hffff_ffff, 48'hffff_ffff_ffff, 1, mk(KIND_DONE, 0, 0, 0, 0, 0, 1));
    for (int i = 0; i < 17; i++) add(FUNC_QUEUE, 32'h0b00_0000 + i, 48'h0);
    add(FUNC_CLEAR, 32'h0, 48'h0, 1, mk(KIND_DONE, 0, 0, 0, 0, 0, 1));
    send_items();
    drain_results();

    // extremes: cache full and short timeout / give-up
    write_register(CFG_TIMEOUT, 16'd1);
    write_register(CFG_MAX_SENDS, 8'd1);
    for (int i = 0; i < 33; i++) add(FUNC_INSERT, 32'h0c00_0000 + i, {16'h0, $urandom});
    for (int i = 0; i < 3; i++) add(FUNC_QUEUE, 32'h0c00_0000 + i, 48'h0);
    repeat (3) add(FUNC_TICK, 32'h0, 48'h0);
    add(FUNC_LOOKUP, 32'h0c00_0001, 48'h0);
    send_items();
    drain_results();

    // long receiver hold-off while items keep coming
    write_register(CFG_TIMEOUT, 16'hffff);
    write_register(CFG_MAX_SENDS, 8'd255);
    for (int i = 0; i < 16; i++) add(FUNC_QUEUE, 32'h0d00_0000 + i, 48'h0);
    add(FUNC_TICK, 32'h0, 48'h0);
    add_random(20);
    fork
      send_items();
      begin
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
    join
    drain_results();

    write_register(CFG_TIMEOUT, 16'd4);
    write_register(CFG_MAX_SENDS, 8'd3);
    add_random(50);
    send_items();
    drain_results();

    write_register(CFG_TIMEOUT, 16'd30);
    write_register(CFG_MAX_SENDS, 8'd5);
    add_random(50);
    send_items();
    drain_results();

    if (errors == 0 && pending_results.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
+incdir+sv
sv/arpc_pkg.sv
sv/arpc_ctrl.sv
sv/arpc_datapath.sv
sv/arp_cache_with_request_retry_top.sv
sv/arpc_checker.sv
sim/arp_cache_with_request_retry_top_tb.sv
